>>> hdl/sfc_pkg.sv
// Shared types and constants for the sphere/frustum cull test.
// Used by sfc_cfg, sfc_plane and sphere_frustum_cull_test; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    localparam int DEF_COORD_WIDTH = 16;
    localparam int NORM_WIDTH      = 16;
    localparam int NORM_FRAC       = 14;
    localparam int NORM_PACK_W     = 3 * NORM_WIDTH;
    localparam int NUM_PLANES      = 6;
    localparam int CFG_IDX_W       = 3;
    // Corner registers hold at most 64 bits; components beyond read as zero.
    localparam int CORNER_MAX_W    = 64;

    // Plane order; the first three planes use the near corner.
    localparam int PLANE_LEFT   = 0;
    localparam int PLANE_FRONT  = 1;
    localparam int PLANE_BOTTOM = 2;
    localparam int PLANE_RIGHT  = 3;
    localparam int PLANE_BACK   = 4;
    localparam int PLANE_TOP    = 5;
    localparam int NEAR_PLANES  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_CORNER   = 3'd0,
        REG_FAR_CORNER    = 3'd1,
        REG_NORMAL_LEFT   = 3'd2,
        REG_NORMAL_FRONT  = 3'd3,
        REG_NORMAL_BOTTOM = 3'd4,
        REG_NORMAL_RIGHT  = 3'd5,
        REG_NORMAL_BACK   = 3'd6,
        REG_NORMAL_TOP    = 3'd7
    } t_cfg_reg;

    // Load enables of the pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

`default_nettype wire

>>> hdl/sfc_cfg.sv
// Frustum configuration registers: two corners and six plane normals.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_cfg #(
    parameter int COORD_WIDTH = sfc_pkg::DEF_COORD_WIDTH,
    localparam int CornerW = (3 * COORD_WIDTH > sfc_pkg::CORNER_MAX_W) ?
                             sfc_pkg::CORNER_MAX_W : 3 * COORD_WIDTH,
    localparam int CfgW    = (CornerW > sfc_pkg::NORM_PACK_W) ?
                             CornerW : sfc_pkg::NORM_PACK_W
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    input  wire [sfc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [CfgW-1:0]                       i_cfg_data,
    output logic [CornerW-1:0]                   o_near,
    output logic [CornerW-1:0]                   o_far,
    output logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::NORM_PACK_W-1:0] o_normal
);

    logic [CornerW-1:0] r_near;
    logic [CornerW-1:0] r_far;
    logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::NORM_PACK_W-1:0] r_normal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= '0;
            r_far    <= '0;
            r_normal <= '0;
        end else if (i_cfg_valid) begin
            case (sfc_pkg::t_cfg_reg'(i_cfg_index))
                sfc_pkg::REG_NEAR_CORNER: begin
                    r_near <= i_cfg_data[CornerW-1:0];
                end
                sfc_pkg::REG_FAR_CORNER: begin
                    r_far <= i_cfg_data[CornerW-1:0];
                end
                sfc_pkg::REG_NORMAL_LEFT: begin
                    r_normal[sfc_pkg::PLANE_LEFT] <= i_cfg_data[sfc_pkg::NORM_PACK_W-1:0];
                end
                sfc_pkg::REG_NORMAL_FRONT: begin
                    r_normal[sfc_pkg::PLANE_FRONT] <= i_cfg_data[sfc_pkg::NORM_PACK_W-1:0];
                end
                sfc_pkg::REG_NORMAL_BOTTOM: begin
                    r_normal[sfc_pkg::PLANE_BOTTOM] <= i_cfg_data[sfc_pkg::NORM_PACK_W-1:0];
                end
                sfc_pkg::REG_NORMAL_RIGHT: begin
                    r_normal[sfc_pkg::PLANE_RIGHT] <= i_cfg_data[sfc_pkg::NORM_PACK_W-1:0];
                end
                sfc_pkg::REG_NORMAL_BACK: begin
                    r_normal[sfc_pkg::PLANE_BACK] <= i_cfg_data[sfc_pkg::NORM_PACK_W-1:0];
                end
                sfc_pkg::REG_NORMAL_TOP: begin
                    r_normal[sfc_pkg::PLANE_TOP] <= i_cfg_data[sfc_pkg::NORM_PACK_W-1:0];
                end
                default: begin
                    r_near <= r_near;
                end
            endcase
        end
    end

    assign o_near   = r_near;
    assign o_far    = r_far;
    assign o_normal = r_normal;

endmodule

`default_nettype wire

>>> hdl/sfc_plane.sv
// Signed distance pipeline for one frustum plane: subtract, multiply, sum,
// then a compare against the scaled radius. Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_plane #(
    parameter int COORD_WIDTH = sfc_pkg::DEF_COORD_WIDTH,
    localparam int CornerW = (3 * COORD_WIDTH > sfc_pkg::CORNER_MAX_W) ?
                             sfc_pkg::CORNER_MAX_W : 3 * COORD_WIDTH,
    localparam int LimW    = COORD_WIDTH - 1 + sfc_pkg::NORM_FRAC
) (
    input  wire                              i_clk,
    input  wire sfc_pkg::t_stage_en          i_en,
    input  wire signed [COORD_WIDTH-1:0]     i_center_x,
    input  wire signed [COORD_WIDTH-1:0]     i_center_y,
    input  wire signed [COORD_WIDTH-1:0]     i_center_z,
    input  wire [CornerW-1:0]                i_corner,
    input  wire [sfc_pkg::NORM_PACK_W-1:0]   i_normal,
    input  wire [LimW-1:0]                   i_lim,
    output logic                             o_below
);

    localparam int PackW   = 3 * COORD_WIDTH;
    localparam int DiffW   = COORD_WIDTH + 1;
    localparam int ProdW   = DiffW + sfc_pkg::NORM_WIDTH;
    localparam int SumW    = ProdW + 2;

    logic [PackW-1:0]                  corner_ext;
    logic signed [COORD_WIDTH-1:0]     center [3];
    logic signed [DiffW-1:0]           n_diff [3];
    logic signed [DiffW-1:0]           r_diff [3];
    logic signed [sfc_pkg::NORM_WIDTH-1:0] nrm [3];
    logic signed [ProdW-1:0]           n_prod [3];
    logic signed [ProdW-1:0]           r_prod [3];
    logic signed [SumW-1:0]            n_sum;
    logic signed [SumW-1:0]            r_sum;
    logic signed [SumW-1:0]            lim_ext;

    // Bits of the packed corner past the register width read as zero.
    assign corner_ext = PackW'(i_corner);
    assign center[0]  = i_center_x;
    assign center[1]  = i_center_y;
    assign center[2]  = i_center_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_diff[k] = DiffW'(center[k]) -
                        DiffW'($signed(corner_ext[k*COORD_WIDTH +: COORD_WIDTH]));
            nrm[k]    = $signed(i_normal[k*sfc_pkg::NORM_WIDTH +: sfc_pkg::NORM_WIDTH]);
            n_prod[k] = ProdW'(r_diff[k]) * ProdW'(nrm[k]);
        end
        n_sum = SumW'(r_prod[0]) + SumW'(r_prod[1]) + SumW'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_diff <= n_diff;
        end
        if (i_en.s2) begin
            r_prod <= n_prod;
        end
        if (i_en.s3) begin
            r_sum <= n_sum;
        end
    end

    assign lim_ext = $signed(SumW'(i_lim));
    assign o_below = (r_sum < lim_ext);

endmodule

`default_nettype wire

>>> hdl/sphere_frustum_cull_test.sv
// Top level of the sphere/frustum cull test: configuration port, six plane
// pipelines and the valid/stall control. Depends on sfc_pkg, sfc_cfg, sfc_plane.
`timescale 1ns / 1ps
`default_nettype none

// One sphere is accepted per clock cycle while o_in_stall is low, and its
// verdict is built in stages: stage one subtracts the frustum corner from the
// center, stage two multiplies by the plane normals, stage three sums the three
// terms per plane, and stage four compares the six distances with the radius
// and registers the combined result. Stalls hold each stage in place; an empty
// stage still takes new data, so bubbles close up while the output is held.
// Configuration writes are always ready and take effect on the next cycle;
// change them only while no sphere is in flight.
module sphere_frustum_cull_test #(
    parameter int COORD_WIDTH = sfc_pkg::DEF_COORD_WIDTH,
    localparam int CornerW = (3 * COORD_WIDTH > sfc_pkg::CORNER_MAX_W) ?
                             sfc_pkg::CORNER_MAX_W : 3 * COORD_WIDTH,
    localparam int CfgW    = (CornerW > sfc_pkg::NORM_PACK_W) ?
                             CornerW : sfc_pkg::NORM_PACK_W
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire signed [COORD_WIDTH-1:0]     i_center_x,
    input  wire signed [COORD_WIDTH-1:0]     i_center_y,
    input  wire signed [COORD_WIDTH-1:0]     i_center_z,
    input  wire [COORD_WIDTH-2:0]            i_radius,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_inside_res,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [sfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [CfgW-1:0]                   i_cfg_data
);

    localparam int LimW    = COORD_WIDTH - 1 + sfc_pkg::NORM_FRAC;

    sfc_pkg::t_stage_en  en;
    logic                r_v1, r_v2, r_v3, r_v4;
    logic [COORD_WIDTH-2:0] r_rad1, r_rad2, r_rad3;
    logic [LimW-1:0]     lim;
    logic [sfc_pkg::NUM_PLANES-1:0] below;
    logic                r_inside;

    logic [CornerW-1:0]  near_corner;
    logic [CornerW-1:0]  far_corner;
    logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::NORM_PACK_W-1:0] normal;

    assign o_cfg_ready = 1'b1;

    sfc_cfg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_near      (near_corner),
        .o_far       (far_corner),
        .o_normal    (normal)
    );

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        en.s4 = !r_v4 || !i_out_stall;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign o_in_stall = !en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= i_in_valid;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
            if (en.s4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_rad1 <= i_radius;
        end
        if (en.s2) begin
            r_rad2 <= r_rad1;
        end
        if (en.s3) begin
            r_rad3 <= r_rad2;
        end
        if (en.s4) begin
            r_inside <= &below;
        end
    end

    // The radius is brought to the product format (22 fraction bits at Q8.8).
    assign lim = {r_rad3, {sfc_pkg::NORM_FRAC{1'b0}}};

    for (genvar g = 0; g < sfc_pkg::NUM_PLANES; g++) begin : g_plane
        sfc_plane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_plane (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_center_x (i_center_x),
            .i_center_y (i_center_y),
            .i_center_z (i_center_z),
            .i_corner   ((g < sfc_pkg::NEAR_PLANES) ? near_corner : far_corner),
            .i_normal   (normal[g]),
            .i_lim      (lim),
            .o_below    (below[g])
        );
    end

    assign o_out_valid  = r_v4;
    assign o_inside_res = r_inside;

endmodule

`default_nettype wire
